[sv/ascii_integer_parser_macros.svh]
// ----------------------------------------------------------------------------
// ASCII integer parser assertion macros
// Shared concurrent assertion forms for the parser's internal checks.
// ----------------------------------------------------------------------------
`ifndef ASCII_INTEGER_PARSER_MACROS_SVH
`define ASCII_INTEGER_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AIP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aip: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AIP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aip: next-cycle check failed");

`endif

[sv/aip_pkg.sv]
// ----------------------------------------------------------------------------
// ASCII integer parser package
// Widths, character codes, parse phases and the types passed between parts.
// ----------------------------------------------------------------------------
package aip_pkg;

   localparam int CHAR_W      = 8;
   localparam int VALUE_W     = 64;
   localparam int COUNT_W     = 8;
   localparam int DIGIT_W     = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

   // Character codes.
   localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
   localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
   localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;

   // Letter digits sit nine above their low nibble.
   localparam logic [DIGIT_W-1:0] HEX_LETTER_OFFSET = 4'd9;

   // Result error codes.
   localparam logic ERR_NONE     = 1'b0;
   localparam logic ERR_NO_DIGIT = 1'b1;

   // Parse phases, one-hot.
   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_ZERO   = 6'b000010,
      PH_SIGN   = 6'b000100,
      PH_HEXPFX = 6'b001000,
      PH_DEC    = 6'b010000,
      PH_HEX    = 6'b100000
   } phase_type;

   // A classified character as the front end hands it to the back end.
   typedef struct packed {
      logic               first;
      logic               is_zero;
      logic               is_plus;
      logic               is_minus;
      logic               is_x;
      logic               is_dec;
      logic               is_hex;
      logic [DIGIT_W-1:0] digit;
   } char_class_type;

   // Queue status seen by both ends.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[sv/aip_if.sv]
// ----------------------------------------------------------------------------
// ASCII integer parser channels
// Valid/ready channels for characters in and parsed numbers out.
// ----------------------------------------------------------------------------
interface aip_req_if;
   logic                         valid;
   logic                         ready;
   logic [aip_pkg::CHAR_W-1:0]   ch;
   logic                         first;

   modport source (output valid, output ch, output first, input ready);
   modport sink   (input valid, input ch, input first, output ready);
endinterface

interface aip_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [aip_pkg::VALUE_W-1:0] value;
   logic                               error;
   logic [aip_pkg::COUNT_W-1:0]        chars_used;

   modport source (output valid, output value, output error, output chars_used,
                   input ready);
   modport sink   (input valid, input value, input error, input chars_used,
                   output ready);
endinterface

[sv/aip_front.sv]
// ----------------------------------------------------------------------------
// ASCII integer parser front end
// Accepts characters and classifies each one for the back end's queue.
// ----------------------------------------------------------------------------
module aip_front (
   aip_req_if.sink                 req_bus,
   input  aip_pkg::queue_status_type q_status,
   output logic                    q_push,
   output aip_pkg::char_class_type q_data
);
   import aip_pkg::*;

   // The front end takes an item whenever the queue has room.
   assign req_bus.ready = !q_status.full;
   assign q_push        = req_bus.valid && !q_status.full;

   // Character classification.
   always_comb begin
      q_data          = '0;
      q_data.first    = req_bus.first;
      q_data.is_zero  = (req_bus.ch == CH_DIGIT_0);
      q_data.is_plus  = (req_bus.ch == CH_PLUS);
      q_data.is_minus = (req_bus.ch == CH_MINUS);
      q_data.is_x     = (req_bus.ch == CH_LOWER_X) || (req_bus.ch == CH_UPPER_X);
      q_data.is_dec   = req_bus.ch inside {[CH_DIGIT_0:CH_DIGIT_9]};
      q_data.is_hex   = q_data.is_dec ||
                        (req_bus.ch inside {[CH_LOWER_A:CH_LOWER_F]}) ||
                        (req_bus.ch inside {[CH_UPPER_A:CH_UPPER_F]});
      // Digits keep their low nibble; letters a-f and A-F add nine to it.
      if (q_data.is_dec) begin
         q_data.digit = req_bus.ch[DIGIT_W-1:0];
      end else begin
         q_data.digit = req_bus.ch[DIGIT_W-1:0] + HEX_LETTER_OFFSET;
      end
   end

endmodule

[sv/aip_queue.sv]
// ----------------------------------------------------------------------------
// ASCII integer parser queue
// Short first-in first-out buffer of classified characters between the ends.
// ----------------------------------------------------------------------------
module aip_queue #(
   parameter int Depth = aip_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  aip_pkg::char_class_type   push_data,
   input  logic                      pop,
   output aip_pkg::char_class_type   pop_data,
   output aip_pkg::queue_status_type status
);
   import aip_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [CntW-1:0] DepthCount = CntW'(Depth);

   char_class_type  slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff,  count_in;

   assign status.full  = (count_ff == DepthCount);
   assign status.empty = (count_ff == '0);
   assign pop_data     = slot_ff[rd_ptr_ff];

   // Pointer and fill count update, with wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/aip_back.sv]
// ----------------------------------------------------------------------------
// ASCII integer parser back end
// Runs the parse state machine and accumulator and holds the result register.
// ----------------------------------------------------------------------------
module aip_back (
   input  logic                      clock,
   input  logic                      reset,
   input  aip_pkg::queue_status_type q_status,
   input  aip_pkg::char_class_type   q_data,
   output logic                      q_pop,
   aip_rsp_if.source                 rsp_bus
);
   import aip_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [VALUE_W-1:0]  acc_ff, acc_in;
   logic                neg_ff, neg_in;
   logic [COUNT_W-1:0]  used_ff, used_in;
   logic [COUNT_W-1:0]  used_bump;
   logic [VALUE_W-1:0]  digit_ext;
   logic [VALUE_W-1:0]  acc_times_ten;
   logic [VALUE_W-1:0]  acc_negated;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic                rsp_error_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic                emit;
   logic [VALUE_W-1:0]  emit_value;
   logic                emit_error;
   logic                slot_free;

   // An item is taken from the queue whenever the result register can accept.
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign q_pop     = !q_status.empty && slot_free;

   // Arithmetic helpers: saturating count, times ten, negation.
   assign used_bump     = (used_ff == COUNT_MAX) ? used_ff : used_ff + COUNT_ONE;
   assign digit_ext     = VALUE_W'(q_data.digit);
   assign acc_times_ten = {acc_ff[VALUE_W-4:0], 3'b000} + {acc_ff[VALUE_W-2:0], 1'b0};
   assign acc_negated   = '0 - acc_ff;

   // Parse state machine.
   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      neg_in     = neg_ff;
      used_in    = used_ff;
      emit       = 1'b0;
      emit_value = '0;
      emit_error = ERR_NONE;
      if (q_pop) begin
         if (q_data.first) begin
            // A flagged character starts over, dropping any parse in progress.
            acc_in  = '0;
            neg_in  = 1'b0;
            used_in = COUNT_ONE;
            if (q_data.is_zero) begin
               phase_in = PH_ZERO;
            end else if (q_data.is_plus) begin
               phase_in = PH_SIGN;
            end else if (q_data.is_minus) begin
               neg_in   = 1'b1;
               phase_in = PH_SIGN;
            end else if (q_data.is_dec) begin
               acc_in   = digit_ext;
               phase_in = PH_DEC;
            end else begin
               used_in    = '0;
               emit       = 1'b1;
               emit_error = ERR_NO_DIGIT;
               phase_in   = PH_IDLE;
            end
         end else begin
            case (phase_ff)
               PH_ZERO: begin
                  if (q_data.is_x) begin
                     phase_in = PH_HEXPFX;
                     used_in  = used_bump;
                  end else if (q_data.is_dec) begin
                     acc_in   = digit_ext;
                     phase_in = PH_DEC;
                     used_in  = used_bump;
                  end else begin
                     emit     = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
               PH_SIGN: begin
                  if (q_data.is_dec) begin
                     acc_in   = digit_ext;
                     phase_in = PH_DEC;
                     used_in  = used_bump;
                  end else begin
                     emit       = 1'b1;
                     emit_error = ERR_NO_DIGIT;
                     phase_in   = PH_IDLE;
                  end
               end
               PH_HEXPFX: begin
                  if (q_data.is_hex) begin
                     acc_in   = digit_ext;
                     phase_in = PH_HEX;
                     used_in  = used_bump;
                  end else begin
                     emit       = 1'b1;
                     emit_error = ERR_NO_DIGIT;
                     phase_in   = PH_IDLE;
                  end
               end
               PH_DEC: begin
                  if (q_data.is_dec) begin
                     acc_in  = acc_times_ten + digit_ext;
                     used_in = used_bump;
                  end else begin
                     emit       = 1'b1;
                     emit_value = neg_ff ? acc_negated : acc_ff;
                     phase_in   = PH_IDLE;
                  end
               end
               PH_HEX: begin
                  if (q_data.is_hex) begin
                     acc_in  = {acc_ff[VALUE_W-DIGIT_W-1:0], q_data.digit};
                     used_in = used_bump;
                  end else begin
                     emit       = 1'b1;
                     emit_value = acc_ff;
                     phase_in   = PH_IDLE;
                  end
               end
               PH_IDLE: begin
                  // Characters outside a number are dropped.
                  phase_in = PH_IDLE;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // Result register valid: set by a finished number, cleared when taken.
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_value_ff <= emit_value;
         rsp_error_ff <= emit_error;
         rsp_count_ff <= used_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.value      = signed'(rsp_value_ff);
   assign rsp_bus.error      = rsp_error_ff;
   assign rsp_bus.chars_used = rsp_count_ff;

endmodule

[sv/ascii_integer_parser.sv]
// ----------------------------------------------------------------------------
// ASCII integer parser
// Streaming parser of decimal and 0x-prefixed hexadecimal integers.
// ----------------------------------------------------------------------------
// Characters enter on req_bus one item per clock while the queue has room. A
// character with first set starts a new number. A leading "0x" or "0X" selects
// hexadecimal; otherwise an optional sign precedes decimal digits, and the
// 64-bit value wraps. The first character that cannot continue a number ends
// it, is not counted, and produces one item on rsp_bus with the value, an
// error flag and the count of characters used (saturating at 255). The block
// sustains one character per clock while results are taken: a small queue
// separates the classifying front end from the state machine, whose
// accumulator step (one times-ten add or a 4-bit shift) is combinational. A
// result is presented on the cycle after the popped ending character, held in
// an output register; while that register is full and not taken the back end
// stalls and the queue absorbs up to QueueDepth further characters.
`include "ascii_integer_parser_macros.svh"

module ascii_integer_parser #(
   parameter int QueueDepth = aip_pkg::QUEUE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   aip_req_if.sink    req_bus,
   aip_rsp_if.source  rsp_bus
);
   import aip_pkg::*;

   queue_status_type q_status;
   char_class_type   q_push_data;
   char_class_type   q_pop_data;
   logic             q_push;
   logic             q_pop;

   // Front end: handshake and character classification.
   aip_front u_front (
      .req_bus  (req_bus),
      .q_status (q_status),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   // Queue between the two ends.
   aip_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // Back end: parse state machine and result register.
   aip_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_data   (q_pop_data),
      .q_pop    (q_pop),
      .rsp_bus  (rsp_bus)
   );

   // The back end never pops an empty queue.
   `AIP_ASSERT_SAME(a_pop_not_empty, clock, reset, q_pop, !q_status.empty)
   // An error result always carries a zero value.
   `AIP_ASSERT_SAME(a_error_value_zero, clock, reset, rsp_bus.valid && rsp_bus.error, rsp_bus.value == '0)
   // An error result has used at most a sign or a hex prefix.
   `AIP_ASSERT_SAME(a_error_count_small, clock, reset, rsp_bus.valid && rsp_bus.error, rsp_bus.chars_used <= COUNT_W'(2))
   // A full queue with no pop stays full into the next cycle.
   `AIP_ASSERT_NEXT(a_full_holds, clock, reset, q_status.full && !q_pop, q_status.full)

endmodule
